// ===== sv/qte_pkg.sv =====
// Shared constants, widths and the arctangent table for the quaternion to
// Euler angle unit. No dependencies.
`default_nettype none

package qte_pkg;

  // Default parameter values for the top level
  localparam int QUAT_WIDTH_DEF    = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Working formats: Q.28 products, doubled sums, clamped sine
  localparam int WORK_FRAC = 28;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 35;
  localparam int SIN_W     = 30;
  // Root bits of the cosine square root, radicand is twice as wide
  localparam int SQRT_B    = 29;
  localparam int RAD_W     = 2 * SQRT_B;
  // Internal angle width, pi = 2^31
  localparam int ZW        = 34;

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd2147483648;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1073741824;

  // atan(2^-i) in units where pi = 2^31
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      5'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qte_isqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
// Depends on qte_pkg for the root and radicand widths.
`default_nettype none

module qte_isqrt
  import qte_pkg::*;
(
  input  logic                clk_i,
  input  logic [SQRT_B-1:0]   en_i,    // per-stage load enable
  input  logic [RAD_W-1:0]    rad_i,
  output logic [SQRT_B-1:0]   root_o
);

  localparam int RW = SQRT_B + 4;

  logic [RW-1:0]     rem_q  [SQRT_B];
  logic [SQRT_B-1:0] root_q [SQRT_B];
  logic [RAD_W-1:0]  rest_q [SQRT_B];

  for (genvar k = 0; k < SQRT_B; k++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [SQRT_B-1:0] root_in;
    logic [RAD_W-1:0]  rest_in;
    logic [RW-1:0]     r2;
    logic [RW-1:0]     trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rest_in = rest_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1
    assign r2    = {rem_in[RW-3:0], rest_in[RAD_W-1 -: 2]};
    assign trial = RW'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rest_q[k] <= rest_in << 2;
        if (r2 >= trial) begin
          rem_q[k]  <= r2 - trial;
          root_q[k] <= {root_in[SQRT_B-2:0], 1'b1};
        end else begin
          rem_q[k]  <= r2;
          root_q[k] <= {root_in[SQRT_B-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_B-1];

endmodule

`default_nettype wire

// ===== sv/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation and output
// rounding to a binary angle. Depends on qte_pkg for widths and the table.
`default_nettype none

module qte_cordic
  import qte_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic [CORDIC_STAGES+1:0]      en_i,   // pre stage, iterations, round
  input  logic signed [SUM_W-1:0]       y_i,
  input  logic signed [SUM_W-1:0]       x_i,
  output logic signed [ANGLE_WIDTH-1:0] angle_o
);

  localparam int NS      = CORDIC_STAGES;
  localparam int CW      = SUM_W + 3;
  localparam int SH      = 32 - ANGLE_WIDTH;
  localparam int HALF_SH = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [ZW-1:0] RND = (SH > 0) ? (ZW'(1) <<< HALF_SH) : '0;

  logic signed [CW-1:0] x_q  [NS+1];
  logic signed [CW-1:0] y_q  [NS+1];
  logic signed [ZW-1:0] z_q  [NS+1];
  logic signed [ZW-1:0] zs_q [NS+1];
  logic                 sp_q [NS+1];
  logic signed [ANGLE_WIDTH-1:0] angle_q;

  logic signed [CW-1:0] x_ext, y_ext;
  assign x_ext = CW'(x_i);
  assign y_ext = CW'(y_i);

  // Pre-rotate into the right half plane; note the vertical-axis case
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sp_q[0] <= (x_ext == '0);
      if (y_ext > 0) begin
        zs_q[0] <= ANG_HALF_PI;
      end else if (y_ext < 0) begin
        zs_q[0] <= -ANG_HALF_PI;
      end else begin
        zs_q[0] <= '0;
      end
      if (x_ext < 0) begin
        x_q[0] <= -x_ext;
        y_q[0] <= -y_ext;
        z_q[0] <= (y_ext >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x_q[0] <= x_ext;
        y_q[0] <= y_ext;
        z_q[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = $signed({2'b00, atan_lut(5'(i))});

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        sp_q[i+1] <= sp_q[i];
        zs_q[i+1] <= zs_q[i];
        if (y_q[i] < 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  // Round half up to the output width and wrap
  logic signed [ZW-1:0] zf, rsum, rsh;
  always_comb begin
    zf   = sp_q[NS] ? zs_q[NS] : z_q[NS];
    rsum = zf + RND;
    rsh  = rsum >>> SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NS+1]) begin
      angle_q <= rsh[ANGLE_WIDTH-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== sv/quaternion_to_euler_angles_unit.sv =====
// Top level of the quaternion to Euler angle (Z-Y-X roll, pitch, yaw) unit.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
//
// Usage:
//   Slave stream takes one quaternion word (w, x, y, z) per handshake; the
//   master stream returns one word per quaternion holding roll, pitch and yaw
//   as binary angles (half scale = pi) and a clamp flag on tuser.
//   The pipeline has one stage for the products, one for the sums and sine
//   clamp, one for the sine square, 29 square-root stages (one root bit each)
//   and the CORDIC pipelines (pre-rotation, CORDIC_STAGES micro-rotations,
//   rounding). Throughput is one word per cycle while the receiver does not
//   stall. Every stage has its own valid bit and loads whenever it is empty
//   or the stage after it moves, so bubbles close up: when the receiver
//   stalls, the result is held on the master side and words keep entering
//   until the pipeline is full; only then does s_axis_tready drop. Nothing
//   is lost or repeated.
//   Reset clears all valid bits; the block keeps no other state.
`default_nettype none

module quaternion_to_euler_angles_unit
  import qte_pkg::*;
#(
  parameter int QUAT_WIDTH    = QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int IN_DW  = ((4 * QUAT_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic [0:0]        m_axis_tuser    // pitch_clamped
);

  localparam int QW    = QUAT_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int CS    = CORDIC_STAGES;
  localparam int FB    = 2 * (QW - 2);
  localparam int SH_R  = (FB >= WORK_FRAC) ? FB - WORK_FRAC : 0;
  localparam int SH_L  = (FB >= WORK_FRAC) ? 0 : WORK_FRAC - FB;
  localparam int C0    = 3 + SQRT_B;
  localparam int NST   = C0 + CS + 2;

  localparam logic signed [SUM_W-1:0]     ONE    = SUM_W'(1) <<< WORK_FRAC;
  localparam logic signed [2*SIN_W-1:0]   ONE_SQ = (2*SIN_W)'(1) <<< (2*WORK_FRAC);
  localparam logic signed [AW-1:0]        HALF_OUT = AW'(1) <<< (AW - 2);

  // ---------------------------------------------------------------- control
  logic [NST-1:0] v_q, v_d, en;

  // Each stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? s_axis_tvalid : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NST-1];

  // ---------------------------------------------------------------- products
  logic signed [QW-1:0] qw, qx, qy, qz;
  assign qw = s_axis_tdata[0*QW +: QW];
  assign qx = s_axis_tdata[1*QW +: QW];
  assign qy = s_axis_tdata[2*QW +: QW];
  assign qz = s_axis_tdata[3*QW +: QW];

  logic signed [2*QW-1:0] f_wx, f_yz, f_xx, f_yy, f_wz, f_xy, f_zz, f_wy, f_zx;
  assign f_wx = qw * qx;
  assign f_yz = qy * qz;
  assign f_xx = qx * qx;
  assign f_yy = qy * qy;
  assign f_wz = qw * qz;
  assign f_xy = qx * qy;
  assign f_zz = qz * qz;
  assign f_wy = qw * qy;
  assign f_zx = qz * qx;

  logic signed [PROD_W-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q;
  logic signed [PROD_W-1:0] p_xy_q, p_zz_q, p_wy_q, p_zx_q;

  // Rescale each product to Q.28 and register
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_wx_q <= PROD_W'(f_wx >>> SH_R) <<< SH_L;
      p_yz_q <= PROD_W'(f_yz >>> SH_R) <<< SH_L;
      p_xx_q <= PROD_W'(f_xx >>> SH_R) <<< SH_L;
      p_yy_q <= PROD_W'(f_yy >>> SH_R) <<< SH_L;
      p_wz_q <= PROD_W'(f_wz >>> SH_R) <<< SH_L;
      p_xy_q <= PROD_W'(f_xy >>> SH_R) <<< SH_L;
      p_zz_q <= PROD_W'(f_zz >>> SH_R) <<< SH_L;
      p_wy_q <= PROD_W'(f_wy >>> SH_R) <<< SH_L;
      p_zx_q <= PROD_W'(f_zx >>> SH_R) <<< SH_L;
    end
  end

  // ---------------------------------------------------------------- sums
  logic signed [SUM_W-1:0] s_full;
  assign s_full = (SUM_W'(p_wy_q) - SUM_W'(p_zx_q)) <<< 1;

  logic signed [SUM_W-1:0] ry_q, rx_q, yy_q, yx_q;
  logic signed [SIN_W-1:0] sn_q;
  logic                    cl_q;

  // Form the atan2 operands and saturate the sine
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ry_q <= (SUM_W'(p_wx_q) + SUM_W'(p_yz_q)) <<< 1;
      rx_q <= ONE - ((SUM_W'(p_xx_q) + SUM_W'(p_yy_q)) <<< 1);
      yy_q <= (SUM_W'(p_wz_q) + SUM_W'(p_xy_q)) <<< 1;
      yx_q <= ONE - ((SUM_W'(p_yy_q) + SUM_W'(p_zz_q)) <<< 1);
      if (s_full > ONE) begin
        sn_q <= SIN_W'(ONE);
        cl_q <= 1'b1;
      end else if (s_full < -ONE) begin
        sn_q <= SIN_W'(-ONE);
        cl_q <= 1'b1;
      end else begin
        sn_q <= SIN_W'(s_full);
        cl_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- radicand
  logic signed [2*SIN_W-1:0] sq;
  assign sq = sn_q * sn_q;

  logic [RAD_W-1:0]        rad_q;
  logic signed [SUM_W-1:0] ry2_q, rx2_q, yy2_q, yx2_q;
  logic signed [SIN_W-1:0] sn2_q;
  logic                    cl2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rad_q <= RAD_W'(ONE_SQ - sq);
      ry2_q <= ry_q;
      rx2_q <= rx_q;
      yy2_q <= yy_q;
      yx2_q <= yx_q;
      sn2_q <= sn_q;
      cl2_q <= cl_q;
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic [SQRT_B-1:0] root;

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[3 +: SQRT_B]),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Carry the other operands alongside the root stages
  logic signed [SUM_W-1:0] d_ry_q [SQRT_B];
  logic signed [SUM_W-1:0] d_rx_q [SQRT_B];
  logic signed [SUM_W-1:0] d_yy_q [SQRT_B];
  logic signed [SUM_W-1:0] d_yx_q [SQRT_B];
  logic signed [SIN_W-1:0] d_sn_q [SQRT_B];
  logic                    d_cl_q [SQRT_B];

  for (genvar k = 0; k < SQRT_B; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[3]) begin
          d_ry_q[0] <= ry2_q;
          d_rx_q[0] <= rx2_q;
          d_yy_q[0] <= yy2_q;
          d_yx_q[0] <= yx2_q;
          d_sn_q[0] <= sn2_q;
          d_cl_q[0] <= cl2_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[3+k]) begin
          d_ry_q[k] <= d_ry_q[k-1];
          d_rx_q[k] <= d_rx_q[k-1];
          d_yy_q[k] <= d_yy_q[k-1];
          d_yx_q[k] <= d_yx_q[k-1];
          d_sn_q[k] <= d_sn_q[k-1];
          d_cl_q[k] <= d_cl_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- atan2
  logic signed [AW-1:0] roll, pitch, yaw;
  logic signed [SUM_W-1:0] pit_y, pit_x;
  assign pit_y = SUM_W'(d_sn_q[SQRT_B-1]);
  assign pit_x = SUM_W'($signed({1'b0, root}));

  qte_cordic #(.CORDIC_STAGES(CS), .ANGLE_WIDTH(AW)) u_roll (
    .clk_i   (clk_i),
    .en_i    (en[C0 +: CS + 2]),
    .y_i     (d_ry_q[SQRT_B-1]),
    .x_i     (d_rx_q[SQRT_B-1]),
    .angle_o (roll)
  );

  qte_cordic #(.CORDIC_STAGES(CS), .ANGLE_WIDTH(AW)) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en[C0 +: CS + 2]),
    .y_i     (pit_y),
    .x_i     (pit_x),
    .angle_o (pitch)
  );

  qte_cordic #(.CORDIC_STAGES(CS), .ANGLE_WIDTH(AW)) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en[C0 +: CS + 2]),
    .y_i     (d_yy_q[SQRT_B-1]),
    .x_i     (d_yx_q[SQRT_B-1]),
    .angle_o (yaw)
  );

  // Carry the clamp flag through the CORDIC stages
  logic c_cl_q [CS+2];
  for (genvar j = 0; j < CS + 2; j++) begin : g_cl
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[C0]) begin
          c_cl_q[0] <= d_cl_q[SQRT_B-1];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[C0+j]) begin
          c_cl_q[j] <= c_cl_q[j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[0*AW +: AW] = roll;
    m_axis_tdata[1*AW +: AW] = pitch;
    m_axis_tdata[2*AW +: AW] = yaw;
  end
  assign m_axis_tuser = c_cl_q[CS+1];

`ifndef SYNTHESIS
  // A saturated sine gives exactly plus or minus a quarter turn
  a_clamp_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (pitch == HALF_OUT) || (pitch == -HALF_OUT))
    else $error("clamped pitch is not a quarter turn");

  // Input only stalls when the pipeline is full and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&v_q)))
    else $error("input stalled with a bubble in the pipeline");

  // A word taken at the output leaves a hole unless the stage behind refills it
  a_out_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> (m_axis_tvalid == $past(v_q[NST-2])))
    else $error("output valid does not follow the previous stage");
`endif

endmodule

`default_nettype wire
